// File: sv/sod_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sod_pkg;

    // fraction bits of the blep window position
    localparam int QF = 15;
    localparam int CNT_W = $clog2(QF);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(QF - 1);

    // apb register map
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;
    localparam logic [1:0] REG_SHAPE = 2'd0;
    localparam logic [1:0] REG_HIGH  = 2'd1;
    localparam logic [1:0] REG_LOW   = 2'd2;

    // wave shape codes
    localparam logic [1:0] SHAPE_OCT1  = 2'd0;
    localparam logic [1:0] SHAPE_OCT2  = 2'd1;
    localparam logic [1:0] SHAPE_PULSE = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic div;
        logic sqr;
        logic mul;
        logic out;
    } t_cmd;

endpackage

`default_nettype wire

// File: sv/sod_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface sod_in_if #(
    parameter int PHASE_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [PHASE_BITS-1:0] master_phase;
    logic                  wrapped;
    logic [PHASE_BITS-1:0] phase_increment;

    modport source (output valid, output master_phase, output wrapped,
                    output phase_increment, input ready);
    modport sink (input valid, input master_phase, input wrapped,
                  input phase_increment, output ready);
endinterface

interface sod_out_if #(
    parameter int LEVEL_BITS = 16
) ();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS:0]   sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

`default_nettype wire

// File: sv/sod_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module sod_regs
    import sod_pkg::*;
#(
    parameter int LEVEL_BITS = 16
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_AW-1:0]     paddr,
    input  wire logic [APB_DW-1:0]     pwdata,
    output logic      [APB_DW-1:0]     prdata,
    output logic                       pready,
    output logic      [1:0]            o_shape,
    output logic      [LEVEL_BITS-1:0] o_high,
    output logic      [LEVEL_BITS-1:0] o_low
);

    logic [1:0]            r_shape;
    logic [LEVEL_BITS-1:0] r_high;
    logic [LEVEL_BITS-1:0] r_low;
    logic                  wr_en;
    logic [1:0]            idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    assign idx    = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shape <= SHAPE_OCT1;
            r_high  <= LEVEL_BITS'(32'sd32767);
            r_low   <= LEVEL_BITS'(-32'sd32767);
        end else if (wr_en) begin
            case (idx)
                REG_SHAPE: r_shape <= pwdata[1:0];
                REG_HIGH:  r_high  <= pwdata[LEVEL_BITS-1:0];
                REG_LOW:   r_low   <= pwdata[LEVEL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_SHAPE: prdata = APB_DW'(r_shape);
            REG_HIGH:  prdata = APB_DW'(r_high);
            REG_LOW:   prdata = APB_DW'(r_low);
            default:   prdata = '0;
        endcase
    end

    assign o_shape = r_shape;
    assign o_high  = r_high;
    assign o_low   = r_low;

endmodule

`default_nettype wire

// File: sv/sod_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module sod_ctrl
    import sod_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_cmd      o_cmd
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_SQR  = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_FIN  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             fire;
    logic             out_free;

    assign o_in_ready = (r_state == ST_IDLE);
    assign fire       = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (fire) begin
                    o_cmd.load = 1'b1;
                    n_cnt      = '0;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == DIV_LAST) begin
                    n_state = ST_SQR;
                end
            end
            ST_SQR: begin
                o_cmd.sqr = 1'b1;
                n_state   = ST_MUL;
            end
            ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    o_cmd.out = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_fire_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_state == ST_DIV)
        else $error("accepted item did not start division");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && (r_cnt == DIV_LAST) |=> r_state == ST_SQR)
        else $error("division did not end after its last step");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out |-> (!r_out_valid || i_out_ready))
        else $error("result register loaded while holding an untaken result");
`endif

endmodule

`default_nettype wire

// File: sv/sod_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module sod_dp
    import sod_pkg::*;
#(
    parameter int PHASE_BITS = 16,
    parameter int LEVEL_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_cmd                         i_cmd,
    input  wire logic [PHASE_BITS-1:0]        i_master_phase,
    input  wire logic                         i_wrapped,
    input  wire logic [PHASE_BITS-1:0]        i_phase_increment,
    input  wire logic [1:0]                   i_shape,
    input  wire logic [LEVEL_BITS-1:0]        i_high,
    input  wire logic [LEVEL_BITS-1:0]        i_low,
    output logic      [LEVEL_BITS:0]          o_sample
);

    localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
    localparam logic [PHASE_BITS:0]   FULL = {1'b1, {PHASE_BITS{1'b0}}};
    localparam logic [QF:0]           ONE  = {1'b1, {QF{1'b0}}};
    localparam int                    PW   = LEVEL_BITS + QF + 3;
    localparam int                    SW   = LEVEL_BITS + 3;
    localparam logic signed [SW-1:0]  SAT_HI = {3'b000, {LEVEL_BITS{1'b1}}};
    localparam logic signed [SW-1:0]  SAT_LO = {3'b111, {LEVEL_BITS{1'b0}}};

    function automatic logic level_hi(input logic [1:0] shape, input logic q1,
                                      input logic q2);
        logic hi;
        case (shape)
            SHAPE_OCT1:  hi = q1;
            SHAPE_OCT2:  hi = q2;
            SHAPE_PULSE: hi = q1 | q2;
            default:     hi = 1'b0;
        endcase
        return hi;
    endfunction

    logic                         r_q1, r_q2;
    logic                         r_lead, r_win;
    logic signed [LEVEL_BITS-1:0] r_level;
    logic signed [LEVEL_BITS:0]   r_step;
    logic [PHASE_BITS-1:0]        r_rem, r_den;
    logic [QF-1:0]                r_quo;
    logic [QF:0]                  r_rmag;
    logic signed [PW-1:0]         r_prod;
    logic [LEVEL_BITS:0]          r_sample;

    // load path
    logic [PHASE_BITS-1:0]        d_c;
    logic                         lead_c, trail_c;
    logic                         q1n, q2n, s1, s2;
    logic signed [LEVEL_BITS-1:0] lvl_old, lvl_new, lvl_sim;
    logic signed [LEVEL_BITS:0]   step_c;
    logic [PHASE_BITS-1:0]        num_c;

    always_comb begin
        d_c     = (i_phase_increment > HALF) ? HALF : i_phase_increment;
        lead_c  = (d_c != '0) && (i_master_phase < d_c);
        trail_c = (d_c != '0) && !lead_c &&
                  ({1'b0, i_master_phase} > (FULL - {1'b0, d_c}));
        q1n     = i_wrapped ? !r_q1 : r_q1;
        q2n     = (i_wrapped && !r_q1) ? !r_q2 : r_q2;
        s1      = !q1n;
        s2      = !q1n ? !q2n : q2n;
        lvl_old = level_hi(i_shape, r_q1, r_q2) ? i_high : i_low;
        lvl_new = level_hi(i_shape, q1n, q2n) ? i_high : i_low;
        lvl_sim = level_hi(i_shape, s1, s2) ? i_high : i_low;
        if (lead_c && i_wrapped) begin
            step_c = {lvl_new[LEVEL_BITS-1], lvl_new} - {lvl_old[LEVEL_BITS-1], lvl_old};
        end else if (trail_c) begin
            step_c = {lvl_sim[LEVEL_BITS-1], lvl_sim} - {lvl_new[LEVEL_BITS-1], lvl_new};
        end else begin
            step_c = '0;
        end
        num_c = lead_c ? i_master_phase
                       : PHASE_BITS'(FULL - {1'b0, i_master_phase});
    end

    // restoring division step
    logic [PHASE_BITS:0] rem2;
    logic                ge;

    assign rem2 = {r_rem, 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};

    // window shape and correction
    logic [QF:0]            c_w;
    logic [2*QF+1:0]        sq;
    logic signed [QF+1:0]   r_sgn;
    logic signed [SW-1:0]   sum;

    always_comb begin
        c_w = ONE - {1'b0, r_quo};
        sq  = c_w * c_w;
        if (!r_win) begin
            r_sgn = '0;
        end else if (r_lead) begin
            r_sgn = -$signed({1'b0, r_rmag});
        end else begin
            r_sgn = $signed({1'b0, r_rmag});
        end
        sum = SW'(r_level) + SW'($signed(r_prod[PW-1:QF+1]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q1   <= 1'b0;
            r_q2   <= 1'b0;
            r_lead <= 1'b0;
            r_win  <= 1'b0;
        end else if (i_cmd.load) begin
            r_q1   <= q1n;
            r_q2   <= q2n;
            r_lead <= lead_c;
            r_win  <= lead_c || trail_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_level <= lvl_new;
            r_step  <= step_c;
            r_rem   <= num_c;
            r_den   <= d_c;
            r_quo   <= '0;
        end
        if (i_cmd.div) begin
            r_rem <= ge ? PHASE_BITS'(rem2 - {1'b0, r_den}) : rem2[PHASE_BITS-1:0];
            r_quo <= {r_quo[QF-2:0], ge};
        end
        if (i_cmd.sqr) begin
            r_rmag <= sq[2*QF:QF];
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_step) * PW'(r_sgn);
        end
        if (i_cmd.out) begin
            if (sum > SAT_HI) begin
                r_sample <= SAT_HI[LEVEL_BITS:0];
            end else if (sum < SAT_LO) begin
                r_sample <= SAT_LO[LEVEL_BITS:0];
            end else begin
                r_sample <= sum[LEVEL_BITS:0];
            end
        end
    end

    assign o_sample = r_sample;

`ifndef SYNTHESIS
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_win |-> r_rem < r_den)
        else $error("division remainder reached the divisor");
    a_rmag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul |-> r_rmag <= ONE)
        else $error("blep residual magnitude above one");
`endif

endmodule

`default_nettype wire

// File: sv/sub_octave_divider_polyblep_top.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  handshake      payload
// i_in      in   valid/ready    master_phase, wrapped, phase_increment
// o_out     out  valid/ready    sample
// apb       in   psel/penable   paddr, pwdata, prdata (pready tied high)
//
// an item goes from accept to result register through an accept step, the
// shared restoring divider (a 15-bit quotient, one bit per division step), then
// square, multiply and saturate steps
// a new item is accepted while the previous result waits in the output register
// a stalled output holds the finished item in the last step until taken
// synchronous active-low reset clears the divider stages and the controller

module sub_octave_divider_polyblep_top
    import sod_pkg::*;
#(
    parameter int PHASE_BITS = 16,
    parameter int LEVEL_BITS = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    sod_in_if.sink                 i_in,
    sod_out_if.source              o_out,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    t_cmd                  cmd;
    logic [1:0]            shape;
    logic [LEVEL_BITS-1:0] high_lvl;
    logic [LEVEL_BITS-1:0] low_lvl;

    sod_regs #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_shape (shape),
        .o_high  (high_lvl),
        .o_low   (low_lvl)
    );

    sod_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd)
    );

    sod_dp #(
        .PHASE_BITS (PHASE_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_master_phase    (i_in.master_phase),
        .i_wrapped         (i_in.wrapped),
        .i_phase_increment (i_in.phase_increment),
        .i_shape           (shape),
        .i_high            (high_lvl),
        .i_low             (low_lvl),
        .o_sample          (o_out.sample)
    );

endmodule

`default_nettype wire

// File: tb/tb_sub_octave_divider_polyblep_top.sv
`timescale 1ns / 1ps

module tb_sub_octave_divider_polyblep_top;
    import sod_pkg::*;

    localparam int PHASE_W = 16;
    localparam int LEVEL_W = 16;
    localparam longint PHASE_FULL = 64'sd1 << PHASE_W;
    localparam longint PHASE_HALF = PHASE_FULL >>> 1;
    localparam longint ONE_Q15 = 64'sd1 << QF;
    localparam longint SAMPLE_MAX = (64'sd1 << LEVEL_W) - 1;
    localparam longint SAMPLE_MIN = -(64'sd1 << LEVEL_W);
    localparam logic [1:0] SHAPE_NONE = 2'd3;
    localparam int NUM_PHASES = 12;
    localparam int TICKS_PER_PHASE = 96;
    localparam int DRAIN_CYCLES = 40;
    localparam int unsigned CYCLE_LIMIT = 600000;

    localparam logic [1:0] PHASE_SHAPE [NUM_PHASES] = '{
        SHAPE_OCT1, SHAPE_OCT2, SHAPE_PULSE, SHAPE_NONE, SHAPE_OCT1, SHAPE_PULSE,
        SHAPE_OCT2, SHAPE_OCT1, SHAPE_PULSE, SHAPE_OCT2, SHAPE_OCT1, SHAPE_NONE
    };
    localparam int PHASE_HIGH [NUM_PHASES] = '{
        32767, -32768, 32767, 1000, 0, -32768, 0, -32768, 0, 32767, 0, 0
    };
    localparam int PHASE_LOW [NUM_PHASES] = '{
        -32768, 32767, -32768, -1000, 0, -32768, 0, 32767, 0, 32767, 0, 0
    };
    localparam bit PHASE_RAND_LEVELS [NUM_PHASES] = '{
        1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1
    };

    typedef struct packed {
        logic [PHASE_W-1:0] phase;
        logic               wrap;
        logic [PHASE_W-1:0] inc;
    } osc_tick_t;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic pready;

    sod_in_if #(.PHASE_BITS(PHASE_W)) in_ch ();
    sod_out_if #(.LEVEL_BITS(LEVEL_W)) out_ch ();

    sub_octave_divider_polyblep_top #(
        .PHASE_BITS(PHASE_W),
        .LEVEL_BITS(LEVEL_W)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    osc_tick_t pending_ticks[$];
    logic [LEVEL_W:0] expected_samples[$];
    osc_tick_t drv_tick;
    logic [LEVEL_W:0] exp_sample;

    logic [1:0] cfg_shape;
    logic signed [LEVEL_W-1:0] cfg_high;
    logic signed [LEVEL_W-1:0] cfg_low;
    logic [1:0] div_q;

    int src_idle_pct;
    int snk_idle_pct;
    int fail_count;
    int unsigned cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [1:0] clocked(logic [1:0] q);
        return {q[0] ? q[1] : ~q[1], ~q[0]};
    endfunction

    function automatic longint level_of(logic [1:0] q);
        logic hi;
        case (cfg_shape)
            SHAPE_OCT1: hi = q[0];
            SHAPE_OCT2: hi = q[1];
            SHAPE_PULSE: hi = q[0] | q[1];
            default: hi = 1'b0;
        endcase
        return hi ? longint'(cfg_high) : longint'(cfg_low);
    endfunction

    function automatic logic [LEVEL_W:0] predict_sub_sample(logic [PHASE_W-1:0] ph,
                                                            logic wr,
                                                            logic [PHASE_W-1:0] inc);
        longint p, d, frac, c, r, stp, lvl, res;
        p = longint'(ph);
        d = longint'(inc);
        if (d > PHASE_HALF) d = PHASE_HALF;
        stp = 0;
        r = 0;
        lvl = level_of(div_q);
        if (wr) begin
            div_q = clocked(div_q);
            stp = level_of(div_q) - lvl;
            lvl = level_of(div_q);
        end
        if (d > 0) begin
            if (p < d) begin
                frac = (p <<< QF) / d;
                c = ONE_Q15 - frac;
                r = -((c * c) >>> QF);
            end else if (p > PHASE_FULL - d) begin
                frac = ((PHASE_FULL - p) <<< QF) / d;
                c = ONE_Q15 - frac;
                r = (c * c) >>> QF;
                stp = level_of(clocked(div_q)) - lvl;
            end else begin
                stp = 0;
            end
        end
        res = lvl + ((stp * r) >>> 16);
        if (res > SAMPLE_MAX) res = SAMPLE_MAX;
        if (res < SAMPLE_MIN) res = SAMPLE_MIN;
        return res[LEVEL_W:0];
    endfunction

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_samples.push_back(predict_sub_sample(in_ch.master_phase,
                                                              in_ch.wrapped,
                                                              in_ch.phase_increment));
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_ticks.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
                    drv_tick = pending_ticks.pop_front();
                    in_ch.valid <= 1'b1;
                    in_ch.master_phase <= drv_tick.phase;
                    in_ch.wrapped <= drv_tick.wrap;
                    in_ch.phase_increment <= drv_tick.inc;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_samples.size() == 0) begin
                    $error("sample: expected none, actual %0d", $signed(out_ch.sample));
                    fail_count++;
                end else begin
                    exp_sample = expected_samples.pop_front();
                    if (out_ch.sample !== exp_sample) begin
                        $error("sample: expected %0d, actual %0d",
                               $signed(exp_sample), $signed(out_ch.sample));
                        fail_count++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_sub_octave_divider_polyblep_top failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [APB_DW-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= APB_AW'({idx, 2'b00});
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_SHAPE: cfg_shape = val[1:0];
            REG_HIGH: cfg_high = val[LEVEL_W-1:0];
            REG_LOW: cfg_low = val[LEVEL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_for_drain();
        do @(posedge i_clk);
        while (pending_ticks.size() != 0 || in_ch.valid || expected_samples.size() != 0);
    endtask

    task automatic push_tick(input int ph, input bit wr, input int inc);
        osc_tick_t t;
        t.phase = PHASE_W'(ph);
        t.wrap = wr;
        t.inc = PHASE_W'(inc);
        pending_ticks.push_back(t);
    endtask

    // oscillator runs with random increments, mixed with noise and bad wrap flags
    task automatic queue_random_ticks(input int count);
        int left;
        int run_len;
        logic [PHASE_W:0] acc;
        logic [PHASE_W-1:0] inc;
        osc_tick_t t;
        left = count;
        acc = (PHASE_W + 1)'($urandom_range(65535));
        while (left > 0) begin
            case ($urandom_range(9))
                0: inc = '0;
                1: inc = PHASE_W'($urandom_range(65535, 32769));
                2, 3, 4: inc = PHASE_W'($urandom_range(2000, 1));
                default: inc = PHASE_W'($urandom_range(32768, 2000));
            endcase
            run_len = $urandom_range(40, 4);
            while (run_len > 0 && left > 0) begin
                if ($urandom_range(99) < 15) begin
                    t.phase = PHASE_W'($urandom);
                    t.wrap = 1'($urandom);
                    t.inc = PHASE_W'($urandom);
                end else begin
                    acc = {1'b0, acc[PHASE_W-1:0]} + {1'b0, inc};
                    t.phase = acc[PHASE_W-1:0];
                    t.wrap = acc[PHASE_W];
                    t.inc = inc;
                    if ($urandom_range(49) == 0) t.wrap = ~t.wrap;
                end
                pending_ticks.push_back(t);
                run_len--;
                left--;
            end
        end
    endtask

    initial begin
        int hi;
        int lo;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_ch.valid = 1'b0;
        in_ch.master_phase = '0;
        in_ch.wrapped = 1'b0;
        in_ch.phase_increment = '0;
        out_ch.ready = 1'b0;
        cfg_shape = SHAPE_OCT1;
        cfg_high = 16'sd32767;
        cfg_low = -16'sd32767;
        div_q = 2'b00;
        fail_count = 0;
        cycle_count = 0;
        src_idle_pct = 25;
        snk_idle_pct = 59;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // window edges, clamping, zero increment, divider walked through all states
        push_tick(0, 1'b0, 0);
        push_tick(0, 1'b1, 0);
        push_tick(0, 1'b1, 1);
        push_tick(65535, 1'b0, 1);
        push_tick(65535, 1'b0, 2);
        push_tick(65535, 1'b0, 65535);
        push_tick(32768, 1'b0, 32768);
        push_tick(32767, 1'b1, 32768);
        push_tick(32769, 1'b0, 32769);
        push_tick(100, 1'b1, 40000);
        push_tick(65535, 1'b1, 0);
        push_tick(0, 1'b1, 65535);
        push_tick(1000, 1'b1, 1001);
        push_tick(64600, 1'b0, 1000);
        push_tick(200, 1'b1, 1000);
        push_tick(30000, 1'b0, 20000);
        push_tick(50000, 1'b0, 20000);
        push_tick(5000, 1'b1, 20000);
        push_tick(43690, 1'b1, 21845);
        push_tick(65535, 1'b1, 65535);
        wait_for_drain();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph < 4) begin
                src_idle_pct = 25;
                snk_idle_pct = 59;
            end else if (ph < 8) begin
                src_idle_pct = 59;
                snk_idle_pct = 25;
            end else begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            hi = PHASE_RAND_LEVELS[ph] ? int'($signed(16'($urandom))) : PHASE_HIGH[ph];
            lo = PHASE_RAND_LEVELS[ph] ? int'($signed(16'($urandom))) : PHASE_LOW[ph];
            write_reg(REG_SHAPE, APB_DW'(PHASE_SHAPE[ph]));
            write_reg(REG_HIGH, APB_DW'(hi));
            write_reg(REG_LOW, APB_DW'(lo));
            queue_random_ticks(TICKS_PER_PHASE);
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_sub_octave_divider_polyblep_top passed");
        end else begin
            $display("tb_sub_octave_divider_polyblep_top failed");
        end
        $finish;
    end

endmodule

// File: sub_octave_divider_polyblep_top.f
sv/sod_pkg.sv
sv/sod_if.sv
sv/sod_regs.sv
sv/sod_ctrl.sv
sv/sod_dp.sv
sv/sub_octave_divider_polyblep_top.sv
tb/tb_sub_octave_divider_polyblep_top.sv
